// ===== hw/rtl/averaged_adc_seven_segment_driver_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the averaged ADC seven-segment driver
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_ADC_SEVEN_SEGMENT_DRIVER_CORE_MACROS_SVH
`define AVERAGED_ADC_SEVEN_SEGMENT_DRIVER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/adcsev_pkg.sv =====
// ----------------------------------------------------------------------------
// adcsev_pkg
// Shared types, constants and helper functions of the ADC voltmeter driver.
// ----------------------------------------------------------------------------
`default_nettype none

package adcsev_pkg;

  // Defaults of the top-level parameters
  localparam int AVERAGE_LOG2_DEF = 6;
  localparam int SAMPLE_BITS_DEF  = 10;

  // Fixed field widths
  localparam int SAMPLE_W   = 10;
  localparam int SEG_W      = 8;
  localparam int NUM_DIGITS = 4;
  localparam int POS_W      = 2;
  localparam int DIGIT_W    = 4;

  // Average is at most SAMPLE_W bits wide
  localparam int AVG_W = SAMPLE_W;

  // Divide by ten via reciprocal: (v * 205) >> 11, exact for v below 1029
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;
  localparam int DIV10_TEN   = 10;
  localparam int PROD_W      = AVG_W + 8;
  localparam int QUO_W       = PROD_W - DIV10_SHIFT;

  // Queue between front and back (depth is a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [QUO_W-1:0]   quo_t;

  localparam digit_t DIGIT_MAX = 4'd9;
  localparam seg_t   SEG_BLANK = 8'hFF;

  // Active-low glyphs for 0..9, bit0 = segment a, bit7 = dp (off)
  localparam seg_t SEG_GLYPH [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
    8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  // One queued item: refresh flag, new average and scan position
  typedef struct packed {
    logic               upd;
    logic [AVG_W-1:0]   avg;
    logic [POS_W-1:0]   pos;
  } adcsev_entry_t;

  function automatic seg_t glyph(input digit_t d);
    seg_t g;
    if (d > DIGIT_MAX) begin
      g = SEG_BLANK;
    end else begin
      g = SEG_GLYPH[d];
    end
    return g;
  endfunction

  function automatic quo_t div10(input logic [AVG_W-1:0] v);
    logic [PROD_W-1:0] p;
    p = PROD_W'(v) * PROD_W'(DIV10_MUL);
    return p[DIV10_SHIFT +: QUO_W];
  endfunction

  function automatic digit_t rem10(input logic [AVG_W-1:0] v, input quo_t q);
    logic [AVG_W-1:0] t;
    t = v - AVG_W'(q) * AVG_W'(DIV10_TEN);
    return t[DIGIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/adcsev_if.sv =====
// ----------------------------------------------------------------------------
// adcsev_if
// Valid/ready channels: ADC sample in, display beat out.
// ----------------------------------------------------------------------------
`default_nettype none

interface adcsev_in_if;
  logic                           valid;
  logic                           ready;
  logic [adcsev_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface adcsev_out_if;
  logic                             valid;
  logic                             ready;
  logic [adcsev_pkg::SEG_W-1:0]      segments_n;
  logic [adcsev_pkg::NUM_DIGITS-1:0] digit_select_n;

  modport source (output valid, output segments_n, output digit_select_n, input ready);
  modport sink   (input valid, input segments_n, input digit_select_n, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/adcsev_front.sv =====
// ----------------------------------------------------------------------------
// adcsev_front
// Accumulates samples, marks every 2^AVERAGE_LOG2-th one as a display
// refresh carrying the average, and tags each beat with its scan position.
// ----------------------------------------------------------------------------
`default_nettype none

module adcsev_front #(
  parameter int AVERAGE_LOG2 = adcsev_pkg::AVERAGE_LOG2_DEF,
  parameter int SAMPLE_BITS  = adcsev_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  adcsev_in_if.sink                      in_ch,
  output logic                           push_valid,
  input  wire logic                      push_ready,
  output adcsev_pkg::adcsev_entry_t      push_data
);
  import adcsev_pkg::*;

  // Sum cannot overflow: 2^L samples of at most 2^S - 1
  localparam int SUM_W = SAMPLE_BITS + AVERAGE_LOG2;
  localparam int CNT_W = (AVERAGE_LOG2 > 0) ? AVERAGE_LOG2 : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << AVERAGE_LOG2) - 1);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic [SAMPLE_BITS-1:0] sample_m;
  logic [SUM_W-1:0]       sum_add;
  logic                   at_last;
  logic                   accept;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid && push_ready;

  // Upper sample bits are ignored
  assign sample_m = in_ch.sample[SAMPLE_BITS-1:0];
  assign sum_add  = sum_r + SUM_W'(sample_m);
  assign at_last  = (cnt_r == CNT_LAST);

  assign push_data.upd = at_last;
  assign push_data.avg = AVG_W'(sum_add[AVERAGE_LOG2 +: SAMPLE_BITS]);
  assign push_data.pos = pos_r;

  // Accumulator, sample count and scan position
  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (accept) begin
      if (at_last) begin
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_r + 1'b1;
      end
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/adcsev_queue.sv =====
// ----------------------------------------------------------------------------
// adcsev_queue
// Small FIFO that decouples the accumulating front from the display back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "averaged_adc_seven_segment_driver_core_macros.svh"

module adcsev_queue (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push_valid,
  output logic                           push_ready,
  input  wire adcsev_pkg::adcsev_entry_t push_data,
  output logic                           pop_valid,
  input  wire logic                      pop_ready,
  output adcsev_pkg::adcsev_entry_t      pop_data
);
  import adcsev_pkg::*;

  adcsev_entry_t     mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // Pointers wrap naturally, depth is a power of two
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_ALWAYS(a_cnt_range, cnt_r <= QCNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
  `ASSERT_IMPLY(a_ptr_empty, cnt_r == '0, wr_ptr_r == rd_ptr_r, "empty queue with split pointers")
  `ASSERT_NEXT(a_cnt_push, push && !pop, cnt_r == QCNT_W'($past(cnt_r) + 1'b1), "push lost in count")

endmodule

`default_nettype wire

// ===== hw/rtl/adcsev_back.sv =====
// ----------------------------------------------------------------------------
// adcsev_back
// Converts the average to BCD over three stages, updates the shown digits
// and registers one display beat per item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "averaged_adc_seven_segment_driver_core_macros.svh"

module adcsev_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      pop_valid,
  output logic                           pop_ready,
  input  wire adcsev_pkg::adcsev_entry_t pop_data,
  adcsev_out_if.source                   out_ch
);
  import adcsev_pkg::*;

  typedef struct packed {
    logic             upd;
    logic [POS_W-1:0] pos;
    quo_t             q1;
    digit_t           d0;
  } st2_t;

  typedef struct packed {
    logic             upd;
    logic [POS_W-1:0] pos;
    digit_t           q2;
    digit_t           d1;
    digit_t           d0;
  } st3_t;

  logic                     adv;
  logic                     s1_valid_r, s2_valid_r, s3_valid_r;
  adcsev_entry_t            s1_r;
  st2_t                     s2_r, s2_nxt;
  st3_t                     s3_r, s3_nxt;
  digit_t [NUM_DIGITS-1:0]  store_r;
  digit_t [NUM_DIGITS-1:0]  new_digits;
  digit_t                   digit_eff;
  quo_t                     q1_c, q2_c;
  logic                     q3_c;
  logic                     out_valid_r;
  seg_t                     out_seg_r, out_seg_nxt;
  logic [NUM_DIGITS-1:0]    out_dsel_r, out_dsel_nxt;

  // Whole pipe moves when the output slot is free or being taken
  assign adv       = !out_valid_r || out_ch.ready;
  assign pop_ready = adv;

  // Stage 1 -> 2: ones digit
  always_comb begin
    q1_c      = div10(s1_r.avg);
    s2_nxt.upd = s1_r.upd;
    s2_nxt.pos = s1_r.pos;
    s2_nxt.q1  = q1_c;
    s2_nxt.d0  = rem10(s1_r.avg, q1_c);
  end

  // Stage 2 -> 3: tens digit; quotient is at most ten
  always_comb begin
    q2_c      = div10(AVG_W'(s2_r.q1));
    s3_nxt.upd = s2_r.upd;
    s3_nxt.pos = s2_r.pos;
    s3_nxt.q2  = q2_c[DIGIT_W-1:0];
    s3_nxt.d1  = rem10(AVG_W'(s2_r.q1), q2_c);
    s3_nxt.d0  = s2_r.d0;
  end

  // Stage 3: hundreds and thousands, pick the digit and its glyph
  always_comb begin
    q3_c          = (s3_r.q2 >= digit_t'(DIV10_TEN));
    new_digits[0] = s3_r.d0;
    new_digits[1] = s3_r.d1;
    new_digits[2] = q3_c ? s3_r.q2 - digit_t'(DIV10_TEN) : s3_r.q2;
    new_digits[3] = digit_t'(q3_c);
    digit_eff     = s3_r.upd ? new_digits[s3_r.pos] : store_r[s3_r.pos];
    out_seg_nxt   = glyph(digit_eff);
    out_dsel_nxt  = ~(NUM_DIGITS'(1) << s3_r.pos);
  end

  // Valid bits, shown digits and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      store_r     <= '0;
    end else if (adv) begin
      s1_valid_r  <= pop_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
      if (s3_valid_r && s3_r.upd) begin
        store_r <= new_digits;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= pop_data;
      s2_r       <= s2_nxt;
      s3_r       <= s3_nxt;
      out_seg_r  <= out_seg_nxt;
      out_dsel_r <= out_dsel_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.segments_n     = out_seg_r;
  assign out_ch.digit_select_n = out_dsel_r;

  `ASSERT_ALWAYS(a_store_bcd, (store_r[0] <= DIGIT_MAX) && (store_r[1] <= DIGIT_MAX) && (store_r[2] <= DIGIT_MAX) && (store_r[3] <= DIGIT_MAX), "shown digit out of BCD range")
  `ASSERT_IMPLY(a_sel_onehot, out_valid_r, $onehot(~out_dsel_r), "digit select not one-hot")
  `ASSERT_NEXT(a_store_write, adv && s3_valid_r && s3_r.upd, store_r == $past(new_digits), "digit refresh lost")

endmodule

`default_nettype wire

// ===== hw/rtl/averaged_adc_seven_segment_driver_core.sv =====
// ----------------------------------------------------------------------------
// averaged_adc_seven_segment_driver_core
// Averaging voltmeter with a multiplexed four-digit common-anode display.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per tick carrying a 10-bit unsigned ADC sample.
//   out_ch : one beat per input beat: active-low segments (a..g, dp off) and
//            an active-low one-hot digit select, scanning ones..thousands.
//   Every 2^AVERAGE_LOG2 samples the average refreshes the shown digits; the
//   beat of that same sample already shows the new value.
//   Path from input acceptance to output valid: queue write, three BCD
//   conversion stages, output register.
//   Throughput: one item per cycle; the first two BCD stages each hold one
//   constant multiply by the reciprocal of ten, the third a compare/subtract.
//   Reset: sum, sample count, shown digits and scan position clear; no beats
//   are pending and in_ch.ready is high from the first clock edge in reset.
//   Stall: the conversion pipe freezes while out_ch is held; the two-entry
//   queue keeps taking beats until full, then in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module averaged_adc_seven_segment_driver_core #(
  parameter int AVERAGE_LOG2 = adcsev_pkg::AVERAGE_LOG2_DEF,
  parameter int SAMPLE_BITS  = adcsev_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  adcsev_in_if.sink    in_ch,
  adcsev_out_if.source out_ch
);
  import adcsev_pkg::*;

  logic          push_valid;
  logic          push_ready;
  adcsev_entry_t push_data;
  logic          pop_valid;
  logic          pop_ready;
  adcsev_entry_t pop_data;

  // Accumulate and classify
  adcsev_front #(
    .AVERAGE_LOG2 (AVERAGE_LOG2),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decoupling queue
  adcsev_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // BCD conversion and display drive
  adcsev_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
